// ===== rtl/zstd_pkg.sv =====
package zstd_pkg;

    // fixed field widths of the item ports
    localparam int IN_W = 16;
    localparam int Z_W  = 16;

    // defaults for the top level parameters
    localparam int DEPTH_DEF        = 64;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF    = 10;

    // saturation limits of the result
    localparam logic [Z_W-1:0] Z_POS_MAX = 16'h7FFF;
    localparam logic [Z_W-1:0] Z_NEG_MIN = 16'h8000;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;       // store accepted sample, update sums
        logic mul;        // form n*sumsq and sum*sum
        logic var_load;   // variance into root unit, start root
        logic root_step;  // one root iteration
        logic rd;         // read stored sample at index
        logic num;        // numerator n*x - sum
        logic div_init;   // load divider
        logic div_step;   // one divider iteration
        logic out_load;   // result into output register
        logic idx_inc;    // next stored sample
        logic clr;        // start a fresh set
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic last_slot;  // store holds DEPTH-1 samples
        logic idx_last;   // index points at final stored sample
        logic out_free;   // output register can take a result
    } status_t;

endpackage

// ===== rtl/zstd_ctrl.sv =====
module zstd_ctrl
    import zstd_pkg::*;
#(
    parameter int ROOT_STEPS = 32,
    parameter int DIV_STEPS  = 33
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    input  logic    s_tlast,
    output logic    s_tready,
    input  status_t st,
    output cmd_t    cmd
);

    localparam int MAX_STEPS = (ROOT_STEPS > DIV_STEPS) ? ROOT_STEPS : DIV_STEPS;
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);

    typedef enum logic [8:0] {
        ST_LOAD  = 9'b000000001,
        ST_MUL   = 9'b000000010,
        ST_VAR   = 9'b000000100,
        ST_ROOT  = 9'b000001000,
        ST_RD    = 9'b000010000,
        ST_NUM   = 9'b000100000,
        ST_DINIT = 9'b001000000,
        ST_DIV   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                accept;

    assign s_tready = (state_reg == ST_LOAD);
    assign accept   = s_tready && s_tvalid;

    // sequencer
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            ST_LOAD: begin
                if (accept) begin
                    cmd.load = 1'b1;
                    if (s_tlast || st.last_slot) begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_VAR;
            end
            ST_VAR: begin
                cmd.var_load = 1'b1;
                step_next    = STEP_W'(ROOT_STEPS - 1);
                state_next   = ST_ROOT;
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                step_next     = step_reg - 1'b1;
                if (step_reg == '0) begin
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                cmd.rd     = 1'b1;
                state_next = ST_NUM;
            end
            ST_NUM: begin
                cmd.num    = 1'b1;
                state_next = ST_DINIT;
            end
            ST_DINIT: begin
                cmd.div_init = 1'b1;
                step_next    = STEP_W'(DIV_STEPS - 1);
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg - 1'b1;
                if (step_reg == '0) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    if (st.idx_last) begin
                        cmd.clr    = 1'b1;
                        state_next = ST_LOAD;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== rtl/zstd_dp.sv =====
module zstd_dp
    import zstd_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [IN_W-1:0] s_sample,
    input  logic            m_tready,
    output logic            m_tvalid,
    output logic [Z_W-1:0]  m_z_value,
    output logic            m_last_result,
    output logic            m_zero_spread,
    output logic            m_clipped,
    input  cmd_t            cmd,
    output status_t         st
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = SW + CNT_W;
    localparam int SQ_W   = 2 * SW + CNT_W;
    localparam int VAR_W  = 2 * SW + 2 * CNT_W;
    localparam int DEN_W  = SW + CNT_W;
    localparam int NUM_W  = SW + CNT_W + 1;
    localparam int MAG_W  = SW + CNT_W;
    localparam int DIVD_W = MAG_W + FRAC_BITS;

    logic signed [SW-1:0]     x_in;
    logic signed [2*SW-1:0]   sq;
    logic [SW-1:0]            store [DEPTH];
    logic signed [SW-1:0]     rd_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [SQ_W-1:0]          sumsq_reg;
    logic [VAR_W-1:0]         pa_reg;
    logic signed [VAR_W-1:0]  pb_reg;
    logic [VAR_W-1:0]         pa_next;
    logic signed [VAR_W-1:0]  pb_next;
    logic [VAR_W-1:0]         v_reg, r_reg, bit_reg, root_t;
    logic signed [NUM_W-1:0]  nx, num_reg;
    logic [NUM_W-1:0]         num_abs;
    logic                     neg_reg;
    logic [DEN_W-1:0]         den;
    logic [DEN_W:0]           rem_sh;
    logic [DEN_W:0]           rem_reg;
    logic [DIVD_W-1:0]        quo_reg;
    logic                     q_ge;
    logic [Z_W-1:0]           qz;
    logic [Z_W-1:0]           z_calc;
    logic                     clip_calc;
    logic                     den_zero;
    logic                     m_valid_reg;
    logic [Z_W-1:0]           m_z_reg;
    logic                     m_last_reg, m_zs_reg, m_clip_reg;

    // sample read as SAMPLE_WIDTH bit two's complement
    generate
        if (SW <= IN_W) begin : g_narrow
            assign x_in = s_sample[SW-1:0];
        end else begin : g_wide
            assign x_in = {{(SW - IN_W){1'b0}}, s_sample};
        end
    endgenerate

    assign sq = x_in * x_in;

    // sample store
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            store[count_reg[IDX_W-1:0]] <= x_in;
        end
        if (cmd.rd) begin
            rd_reg <= store[idx_reg];
        end
    end

    // count, sums and index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            idx_reg   <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
        end else if (cmd.clr) begin
            count_reg <= '0;
            idx_reg   <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
        end else begin
            if (cmd.load) begin
                count_reg <= count_reg + 1'b1;
                sum_reg   <= sum_reg + {{CNT_W{x_in[SW-1]}}, x_in};
                sumsq_reg <= sumsq_reg + {{CNT_W{1'b0}}, sq};
            end
            if (cmd.idx_inc) begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // variance products
    assign pa_next = count_reg * sumsq_reg;
    assign pb_next = sum_reg * sum_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
        end
    end

    // integer square root, two variance bits per step
    assign root_t = r_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (cmd.var_load) begin
            v_reg   <= pa_reg - $unsigned(pb_reg);
            r_reg   <= '0;
            bit_reg <= {2'b01, {(VAR_W - 2){1'b0}}};
        end else if (cmd.root_step) begin
            if (v_reg >= root_t) begin
                v_reg <= v_reg - root_t;
                r_reg <= (r_reg >> 1) + bit_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign den      = r_reg[DEN_W-1:0];
    assign den_zero = (den == '0);

    // numerator n*x - sum
    assign nx = $signed({1'b0, count_reg}) * rd_reg;

    always_ff @(posedge aclk) begin
        if (cmd.num) begin
            num_reg <= nx - {sum_reg[SUM_W-1], sum_reg};
        end
    end

    assign num_abs = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);

    // restoring divider, one quotient bit per step
    assign rem_sh = {rem_reg[DEN_W-1:0], quo_reg[DIVD_W-1]};
    assign q_ge   = (rem_sh >= {1'b0, den});

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            neg_reg <= num_reg[NUM_W-1];
            rem_reg <= '0;
            quo_reg <= DIVD_W'(num_abs[MAG_W-1:0]) << FRAC_BITS;
        end else if (cmd.div_step) begin
            rem_reg <= q_ge ? (rem_sh - {1'b0, den}) : rem_sh;
            quo_reg <= {quo_reg[DIVD_W-2:0], q_ge};
        end
    end

    // sign and saturation
    assign qz = Z_W'(quo_reg);

    always_comb begin
        z_calc    = '0;
        clip_calc = 1'b0;
        if (!den_zero) begin
            if (neg_reg) begin
                if (quo_reg > 32'd32768) begin
                    z_calc    = Z_NEG_MIN;
                    clip_calc = 1'b1;
                end else begin
                    z_calc = Z_W'(0) - qz;
                end
            end else begin
                if (quo_reg > 32'd32767) begin
                    z_calc    = Z_POS_MAX;
                    clip_calc = 1'b1;
                end else begin
                    z_calc = qz;
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_z_reg    <= z_calc;
            m_last_reg <= st.idx_last;
            m_zs_reg   <= den_zero;
            m_clip_reg <= clip_calc;
        end
    end

    assign m_tvalid      = m_valid_reg;
    assign m_z_value     = m_z_reg;
    assign m_last_result = m_last_reg;
    assign m_zero_spread = m_zs_reg;
    assign m_clipped     = m_clip_reg;

    // status
    assign st.last_slot = (count_reg == CNT_W'(DEPTH - 1));
    assign st.idx_last  = (({1'b0, idx_reg} + 1'b1) == (IDX_W + 1)'(count_reg));
    assign st.out_free  = !m_valid_reg || m_tready;

endmodule

// ===== rtl/zscore_standardizer.sv =====
// channel  | dir | ports                      | contents
// ---------+-----+----------------------------+-----------------------------------------
// s_       | in  | s_tvalid s_tready s_tdata  | tdata[15:0] sample, tlast end_of_set
//          |     | s_tlast                    |
// m_       | out | m_tvalid m_tready m_tdata  | tdata[15:0] z_value, tlast last_result,
//          |     | m_tlast m_tuser            | tuser[0] zero_spread, tuser[1] clipped
//
// Once a set is loaded, the deviation comes from a multiply step, a variance
// load and the square root steps; each result then takes a sample read, a
// numerator step, a divider load, the restoring divider's steps at one quotient
// bit per cycle, and an output load. Input is taken only while loading.
// A stalled m_tready holds the result register and the sequencer waits on it.
// Reset is synchronous, active low; the sample store is not cleared.
module zscore_standardizer
    import zstd_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [IN_W-1:0] s_tdata,   // [15:0] sample
    input  logic            s_tlast,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [Z_W-1:0]  m_tdata,   // [15:0] z_value
    output logic            m_tlast,
    output logic [1:0]      m_tuser    // [0] zero_spread, [1] clipped
);

    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int ROOT_STEPS = SAMPLE_WIDTH + CNT_W;
    localparam int DIV_STEPS  = SAMPLE_WIDTH + CNT_W + FRAC_BITS;

    cmd_t    cmd;
    status_t st;

    zstd_ctrl #(
        .ROOT_STEPS (ROOT_STEPS),
        .DIV_STEPS  (DIV_STEPS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    zstd_dp #(
        .DEPTH        (DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_sample      (s_tdata),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .m_z_value     (m_tdata),
        .m_last_result (m_tlast),
        .m_zero_spread (m_tuser[0]),
        .m_clipped     (m_tuser[1]),
        .cmd           (cmd),
        .st            (st)
    );

`ifndef SYNTHESIS
    // zero spread forces a plain zero result
    a_zero_spread: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
        else $error("zero spread result not zero");

    // a clipped result sits at a range limit
    a_clip_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> (m_tdata == Z_POS_MAX) || (m_tdata == Z_NEG_MIN))
        else $error("clipped result off the limit");

    // no sample taken while a new result is being produced
    a_no_load_on_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) && !m_tlast |-> !s_tready)
        else $error("input open during emission");
`endif

endmodule

// ===== verif/zscore_standardizer_tb.sv =====
`timescale 1ns / 100ps

module zscore_standardizer_tb;
    import zstd_pkg::*;

    localparam int DEPTH     = DEPTH_DEF;
    localparam int FRAC_BITS = FRAC_BITS_DEF;
    localparam int WD_LIMIT  = 200000;

    typedef struct packed {
        logic [Z_W-1:0] z;
        logic           last_res;
        logic           zero_spread;
        logic           clipped;
    } zres_t;

    typedef struct packed {
        logic [IN_W-1:0] sample;
        logic            eos;
    } sitem_t;

    logic aclk;
    logic aresetn;
    logic s_tvalid, s_tready, s_tlast;
    logic [IN_W-1:0] s_tdata;
    logic m_tvalid, m_tready, m_tlast;
    logic [Z_W-1:0] m_tdata;
    logic [1:0] m_tuser;

    zscore_standardizer DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    // predictor state: the current set
    longint set_samples[$];
    longint set_sum;
    longint set_sqsum;

    sitem_t pending_items[$];
    zres_t  expected_z[$];
    int     mismatches;
    int     idle_cycles;
    int     src_idle_pct;
    int     snk_idle_pct;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic longint unsigned isqrt_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // accumulate one sample; close the set on end mark or full store
    task automatic predict_zscores(sitem_t it);
        longint x, n, num;
        longint unsigned var_v, den, mag, q;
        zres_t r;
        x = longint'($signed(it.sample));
        set_samples = {set_samples, x};
        set_sum += x;
        set_sqsum += x * x;
        if (!it.eos && set_samples.size() < DEPTH) return;
        n = set_samples.size();
        var_v = longint'(n * set_sqsum - set_sum * set_sum);
        den = isqrt_floor(var_v);
        for (int k = 0; k < n; k++) begin
            r = '0;
            r.last_res = (k == n - 1);
            r.zero_spread = (den == 0);
            if (den != 0) begin
                num = n * set_samples[k] - set_sum;
                mag = (num < 0) ? -num : num;
                q = (mag << FRAC_BITS) / den;
                if (num < 0) begin
                    if (q > 32768) begin
                        r.z = Z_NEG_MIN;
                        r.clipped = 1'b1;
                    end else begin
                        r.z = Z_W'(-longint'(q));
                    end
                end else if (q > 32767) begin
                    r.z = Z_POS_MAX;
                    r.clipped = 1'b1;
                end else begin
                    r.z = Z_W'(q);
                end
            end
            expected_z = {expected_z, r};
        end
        set_samples.delete();
        set_sum = 0;
        set_sqsum = 0;
    endtask

    task automatic report_mismatch(string what, zres_t got, zres_t exp_r);
        $display("mismatch %s: got z=%h l=%b zs=%b c=%b exp z=%h l=%b zs=%b c=%b", what,
                 got.z, got.last_res, got.zero_spread, got.clipped,
                 exp_r.z, exp_r.last_res, exp_r.zero_spread, exp_r.clipped);
        mismatches++;
    endtask

    // driver: one item per handshake, random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) predict_zscores('{sample: s_tdata, eos: s_tlast});
            if (pending_items.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_items[0].sample;
                s_tlast  <= pending_items[0].eos;
                void'(pending_items.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge aclk) begin
        zres_t got, exp_r;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{z: m_tdata, last_res: m_tlast, zero_spread: m_tuser[0],
                        clipped: m_tuser[1]};
                if (expected_z.size() == 0) begin
                    report_mismatch("unexpected", got, got);
                end else begin
                    exp_r = expected_z.pop_front();
                    if (got.z !== exp_r.z) report_mismatch("z_value", got, exp_r);
                    if (got.last_res !== exp_r.last_res) report_mismatch("last", got, exp_r);
                    if (got.zero_spread !== exp_r.zero_spread)
                        report_mismatch("zero_spread", got, exp_r);
                    if (got.clipped !== exp_r.clipped) report_mismatch("clipped", got, exp_r);
                end
            end
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic add_item(logic [15:0] s, logic e);
        pending_items = {pending_items, sitem_t'{sample: s, eos: e}};
    endtask

    // a set of random length; mostly small, some full-store
    task automatic add_random_set();
        int len, mode;
        logic [15:0] base;
        len = ($urandom_range(9) == 0) ? DEPTH + 2 : $urandom_range(12, 1);
        mode = $urandom_range(3);
        base = 16'($urandom);
        for (int i = 0; i < len; i++) begin
            case (mode)
                0: add_item(16'($urandom), i == len - 1);
                1: add_item(base + 16'($urandom_range(3)), i == len - 1);
                2: add_item(($urandom_range(1) ? 16'h7FFF : 16'h8000), i == len - 1);
                default: add_item(16'($signed(10'($urandom))), i == len - 1);
            endcase
        end
    endtask

    initial begin
        s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0; m_tready = 1'b0;
        aresetn = 1'b0; mismatches = 0; idle_cycles = 0;
        set_sum = 0; set_sqsum = 0;
        src_idle_pct = 20; snk_idle_pct = 87;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: single sample, equal samples, extremes, an outlier, full store
        add_item(16'h1234, 1'b1);
        add_item(16'h8000, 1'b0); add_item(16'h8000, 1'b0); add_item(16'h8000, 1'b1);
        add_item(16'h8000, 1'b0); add_item(16'h7FFF, 1'b1);
        add_item(16'h0000, 1'b0); add_item(16'h0000, 1'b0); add_item(16'h0000, 1'b0);
        add_item(16'h0000, 1'b0); add_item(16'h0000, 1'b0); add_item(16'h7FFF, 1'b1);
        add_item(16'hFFFF, 1'b0); add_item(16'h0001, 1'b0); add_item(16'h5555, 1'b0);
        add_item(16'hAAAA, 1'b1);
        for (int i = 0; i < DEPTH; i++) add_item(16'($urandom), 1'b0);

        // random phases, three idling patterns
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin src_idle_pct = 87; snk_idle_pct = 20; end
            if (ph == 2) begin src_idle_pct = 0;  snk_idle_pct = 0;  end
            while (pending_items.size() < 150) add_random_set();
            wait (pending_items.size() == 0);
        end

        @(posedge aclk);
        while (s_tvalid) @(posedge aclk);
        wait (expected_z.size() == 0);
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && expected_z.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/zstd_pkg.sv
rtl/zstd_ctrl.sv
rtl/zstd_dp.sv
rtl/zscore_standardizer.sv
verif/zscore_standardizer_tb.sv
